// ===== src/lbfsg_pkg.sv =====
// Shared types, constants and the frequency table of the load-based step governor.
package lbfsg_pkg;

    // Number of CPUs whose counters are tracked
    localparam int NUM_CPUS = 4;
    localparam int CPU_AW   = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

    // Frequency table geometry
    localparam logic [3:0] TOP_POS  = 4'd10;
    localparam int         FREQ_W   = 21;

    // Load is a percentage
    localparam int LOAD_PCT = 100;

    // Divider geometry: quotient is at most 100, so 7 bits
    localparam int DELTA_W = 32;
    localparam int QUOT_W  = 7;
    localparam int REM_W   = DELTA_W + QUOT_W;

    // Configuration port geometry and register indexes
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_BASE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_BASE = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OPTIMAL   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST     = 8'd3;

    // Register reset values
    localparam logic [6:0] UP_BASE_RST   = 7'd55;
    localparam logic [6:0] DOWN_BASE_RST = 7'd20;
    localparam logic [3:0] OPTIMAL_RST   = 4'd3;
    localparam logic [3:0] BOOST_RST     = 4'd7;

    // One input beat
    typedef struct packed {
        logic [1:0]        cpu_index;
        logic [63:0]       wall_time_us;
        logic [63:0]       idle_time_us;
        logic              first_of_round;
        logic              last_of_round;
        logic              boost_request;
        logic [FREQ_W-1:0] current_freq_khz;
    } in_t;

    // One result beat
    typedef struct packed {
        logic [FREQ_W-1:0] target_freq_khz;
        logic [3:0]        table_position;
        logic              change_request;
        logic              boost_applied;
    } out_t;

    // Frequency in kHz at a table position
    function automatic logic [FREQ_W-1:0] freq_of(input logic [3:0] pos);
        logic [FREQ_W-1:0] f;
        case (pos)
            4'd0:    f = 21'd384000;
            4'd1:    f = 21'd594000;
            4'd2:    f = 21'd702000;
            4'd3:    f = 21'd810000;
            4'd4:    f = 21'd918000;
            4'd5:    f = 21'd1026000;
            4'd6:    f = 21'd1134000;
            4'd7:    f = 21'd1242000;
            4'd8:    f = 21'd1350000;
            4'd9:    f = 21'd1458000;
            default: f = 21'd1512000;
        endcase
        return f;
    endfunction

endpackage

// ===== src/load_based_frequency_step_governor.sv =====
// A beat is captured, then prepared; a usable sample is multiplied, run through the
// 7-step shared restoring divider and folded into the peak, and a last-of-round beat then
// steps the position up and down and emits it. A boost result goes from prepare to emit.
// No new beat is taken until the last is done; a decision also waits out any result stall.
// Reset (aresetn low, synchronous) clears the stored counters, peak, position and
// round state, and restores the configuration registers to their defaults.
module load_based_frequency_step_governor
    import lbfsg_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_t                  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_t                 m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    // Sequencer codes
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_PEAK = 3'd4;
    localparam logic [2:0] ST_UP   = 3'd5;
    localparam logic [2:0] ST_DOWN = 3'd6;
    localparam logic [2:0] ST_EMIT = 3'd7;

    logic [2:0]          state_reg, state_next;
    in_t                 item_reg, item_next;

    logic [6:0]          up_base_reg, up_base_next;
    logic [6:0]          down_base_reg, down_base_next;
    logic [3:0]          optimal_reg, optimal_next;
    logic [3:0]          boost_pos_reg, boost_pos_next;

    logic [DELTA_W-1:0]  prev_wall_reg [NUM_CPUS];
    logic [DELTA_W-1:0]  prev_wall_next [NUM_CPUS];
    logic [DELTA_W-1:0]  prev_idle_reg [NUM_CPUS];
    logic [DELTA_W-1:0]  prev_idle_next [NUM_CPUS];

    logic [QUOT_W-1:0]   peak_reg, peak_next;
    logic [3:0]          position_reg, position_next;
    logic                round_skipped_reg, round_skipped_next;
    logic [FREQ_W-1:0]   latched_reg, latched_next;
    logic                boost_flag_reg, boost_flag_next;

    logic [DELTA_W-1:0]  diff_reg, diff_next;
    logic [DELTA_W-1:0]  dw_reg, dw_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [REM_W-1:0]    div_reg, div_next;
    logic [QUOT_W-1:0]   quot_reg, quot_next;
    logic [2:0]          cnt_reg, cnt_next;
    logic signed [5:0]   pos_work_reg, pos_work_next;

    logic                m_valid_reg, m_valid_next;
    out_t                m_data_reg, m_data_next;

    // Combinational helpers
    logic [CPU_AW-1:0]   cpu_sel;
    logic                cpu_ok;
    logic [DELTA_W-1:0]  dw, di;
    logic                usable;
    logic [3:0]          boost_idx;
    logic                boost_fire;
    logic                skip_eff;
    logic                div_ge;
    logic signed [9:0]   peak_s, up_thr, down_thr;
    logic signed [5:0]   opt_s, pos_a, pos_b;
    logic [FREQ_W-1:0]   emit_freq;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Sample decode and delta forming
    always_comb begin
        cpu_sel    = CPU_AW'(item_reg.cpu_index);
        cpu_ok     = (32'(item_reg.cpu_index) < NUM_CPUS);
        dw         = item_reg.wall_time_us[DELTA_W-1:0] - prev_wall_reg[cpu_sel];
        di         = item_reg.idle_time_us[DELTA_W-1:0] - prev_idle_reg[cpu_sel];
        usable     = (dw != '0) && (dw >= di);
        boost_idx  = (boost_pos_reg > TOP_POS) ? TOP_POS : boost_pos_reg;
        boost_fire = item_reg.first_of_round && item_reg.boost_request &&
                     (item_reg.current_freq_khz < freq_of(boost_idx));
        skip_eff   = item_reg.first_of_round ? 1'b0 : round_skipped_reg;
        div_ge     = (rem_reg >= div_reg);
    end

    // Position decision arithmetic
    always_comb begin
        peak_s   = $signed({3'b000, peak_reg});
        opt_s    = $signed({2'b00, optimal_reg});
        pos_a    = $signed({2'b00, position_reg});
        up_thr   = $signed({3'b000, up_base_reg}) + $signed({{4{pos_a[5]}}, pos_a});
        down_thr = $signed({3'b000, down_base_reg})
                 + $signed({{4{pos_work_reg[5]}}, pos_work_reg});
        emit_freq = freq_of(position_reg);
    end

    // Sequencer and datapath next state
    always_comb begin
        state_next         = state_reg;
        item_next          = item_reg;
        up_base_next       = up_base_reg;
        down_base_next     = down_base_reg;
        optimal_next       = optimal_reg;
        boost_pos_next     = boost_pos_reg;
        prev_wall_next     = prev_wall_reg;
        prev_idle_next     = prev_idle_reg;
        peak_next          = peak_reg;
        position_next      = position_reg;
        round_skipped_next = round_skipped_reg;
        latched_next       = latched_reg;
        boost_flag_next    = boost_flag_reg;
        diff_next          = diff_reg;
        dw_next            = dw_reg;
        rem_next           = rem_reg;
        div_next           = div_reg;
        quot_next          = quot_reg;
        cnt_next           = cnt_reg;
        pos_work_next      = pos_work_reg;
        pos_b              = pos_work_reg;
        m_valid_next       = m_valid_reg;
        m_data_next        = m_data_reg;

        // Drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // Configuration writes
        if (cfg_valid) begin
            case (cfg_index)
                CFG_UP_BASE:   up_base_next   = cfg_data[6:0];
                CFG_DOWN_BASE: down_base_next = cfg_data[6:0];
                CFG_OPTIMAL:   optimal_next   = cfg_data[3:0];
                CFG_BOOST:     boost_pos_next = cfg_data[3:0];
                default:       ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                // Capture the beat
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                // Round marks, boost check and counter update
                if (item_reg.first_of_round) begin
                    peak_next          = '0;
                    round_skipped_next = 1'b0;
                    latched_next       = item_reg.current_freq_khz;
                end
                if (boost_fire) begin
                    position_next      = boost_idx;
                    boost_flag_next    = 1'b1;
                    round_skipped_next = !item_reg.last_of_round;
                    state_next         = ST_EMIT;
                end else if (skip_eff) begin
                    if (item_reg.last_of_round) begin
                        round_skipped_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end else begin
                    if (cpu_ok) begin
                        prev_wall_next[cpu_sel] = item_reg.wall_time_us[DELTA_W-1:0];
                        prev_idle_next[cpu_sel] = item_reg.idle_time_us[DELTA_W-1:0];
                    end
                    diff_next = dw - di;
                    dw_next   = dw;
                    if (cpu_ok && usable) begin
                        state_next = ST_MUL;
                    end else if (item_reg.last_of_round) begin
                        state_next = ST_UP;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_MUL: begin
                // Scale the busy delta to percent and align the divisor
                rem_next   = REM_W'(diff_reg) * REM_W'(LOAD_PCT);
                div_next   = {1'b0, dw_reg, 6'b000000};
                quot_next  = '0;
                cnt_next   = 3'(QUOT_W - 1);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                // One quotient bit per cycle
                if (div_ge) begin
                    rem_next = rem_reg - div_reg;
                end
                quot_next = {quot_reg[QUOT_W-2:0], div_ge};
                div_next  = div_reg >> 1;
                cnt_next  = cnt_reg - 3'd1;
                if (cnt_reg == 3'd0) begin
                    state_next = ST_PEAK;
                end
            end
            ST_PEAK: begin
                // Track the round's peak load
                if (quot_reg > peak_reg) begin
                    peak_next = quot_reg;
                end
                state_next = item_reg.last_of_round ? ST_UP : ST_IDLE;
            end
            ST_UP: begin
                // Step up, jumping to optimal when below it
                pos_work_next = pos_a;
                if (peak_s > up_thr) begin
                    pos_work_next = pos_a + 6'sd1;
                    if ((pos_a + 6'sd1) < opt_s) begin
                        pos_work_next = opt_s;
                    end
                end
                state_next = ST_DOWN;
            end
            ST_DOWN: begin
                // Step down, falling to optimal when above it, then clamp
                if (peak_s < down_thr) begin
                    pos_b = pos_work_reg - 6'sd1;
                    if (pos_b > opt_s) begin
                        pos_b = opt_s;
                    end
                end
                if (pos_b > $signed({2'b00, TOP_POS})) begin
                    pos_b = $signed({2'b00, TOP_POS});
                end
                if (pos_b < 6'sd0) begin
                    pos_b = 6'sd0;
                end
                position_next   = pos_b[3:0];
                peak_next       = '0;
                boost_flag_next = 1'b0;
                state_next      = ST_EMIT;
            end
            ST_EMIT: begin
                // Load the output register when it is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                = 1'b1;
                    m_data_next.target_freq_khz = emit_freq;
                    m_data_next.table_position  = position_reg;
                    m_data_next.change_request  = (emit_freq != latched_reg);
                    m_data_next.boost_applied   = boost_flag_reg;
                    state_next                  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            up_base_reg       <= UP_BASE_RST;
            down_base_reg     <= DOWN_BASE_RST;
            optimal_reg       <= OPTIMAL_RST;
            boost_pos_reg     <= BOOST_RST;
            for (int i = 0; i < NUM_CPUS; i++) begin
                prev_wall_reg[i] <= '0;
                prev_idle_reg[i] <= '0;
            end
            peak_reg          <= '0;
            position_reg      <= '0;
            round_skipped_reg <= 1'b0;
            latched_reg       <= '0;
            boost_flag_reg    <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            up_base_reg       <= up_base_next;
            down_base_reg     <= down_base_next;
            optimal_reg       <= optimal_next;
            boost_pos_reg     <= boost_pos_next;
            prev_wall_reg     <= prev_wall_next;
            prev_idle_reg     <= prev_idle_next;
            peak_reg          <= peak_next;
            position_reg      <= position_next;
            round_skipped_reg <= round_skipped_next;
            latched_reg       <= latched_next;
            boost_flag_reg    <= boost_flag_next;
            m_valid_reg       <= m_valid_next;
        end
        item_reg     <= item_next;
        diff_reg     <= diff_next;
        dw_reg       <= dw_next;
        rem_reg      <= rem_next;
        div_reg      <= div_next;
        quot_reg     <= quot_next;
        cnt_reg      <= cnt_next;
        pos_work_reg <= pos_work_next;
        m_data_reg   <= m_data_next;
    end

endmodule

// ===== src/lbfsg_checker.sv =====
// Port-level checks for the load-based step governor, bound to the top level.
module lbfsg_checker
    import lbfsg_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input out_t                 m_data
);

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat valid right after reset");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result beat changed");

    // The block is busy for the cycle after it takes a beat
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after acceptance");

    // Table position stays within the table
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.table_position <= TOP_POS))
        else $error("table position beyond the table");

    // A boost result always raises the frequency
    a_boost_change: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.boost_applied |-> m_data.change_request)
        else $error("boost result without change request");

endmodule

bind load_based_frequency_step_governor lbfsg_checker u_lbfsg_checker (.*);

// ===== test/load_based_frequency_step_governor_test.sv =====
// Self-checking testbench for the load-based frequency step governor.
`timescale 1ns / 1ps

import lbfsg_pkg::*;

// Tracks the governor state per accepted sample beat and checks each decision beat.
class decision_scoreboard;
    // Register copies
    bit [6:0]  up_base;
    bit [6:0]  down_base;
    bit [3:0]  optimal_pos;
    bit [3:0]  boost_pos;

    // Governor state
    bit [63:0] last_wall [NUM_CPUS];
    bit [63:0] last_idle [NUM_CPUS];
    int        peak;
    int        pos;
    bit        skipping;
    bit [20:0] latched_freq;

    bit [20:0] freq_at [0:10];
    out_t      expected_decisions [$];

    // Run statistics
    int errors;
    int samples;
    int decisions;
    int boosts;
    int changes;
    int reg_writes;
    int pos_low;
    int pos_high;

    function new();
        freq_at = '{21'd384000, 21'd594000, 21'd702000, 21'd810000, 21'd918000,
                    21'd1026000, 21'd1134000, 21'd1242000, 21'd1350000, 21'd1458000,
                    21'd1512000};
        up_base      = 7'd55;
        down_base    = 7'd20;
        optimal_pos  = 4'd3;
        boost_pos    = 4'd7;
        foreach (last_wall[i]) begin
            last_wall[i] = '0;
            last_idle[i] = '0;
        end
        peak         = 0;
        pos          = 0;
        skipping     = 0;
        latched_freq = '0;
        pos_low      = 15;
        pos_high     = 0;
    endfunction

    function int pending();
        return expected_decisions.size();
    endfunction

    task report(string msg);
        errors++;
        $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    function void set_register(bit [CFG_IDX_W-1:0] idx, bit [CFG_DAT_W-1:0] data);
        reg_writes++;
        case (idx)
            CFG_UP_BASE:   up_base     = data[6:0];
            CFG_DOWN_BASE: down_base   = data[6:0];
            CFG_OPTIMAL:   optimal_pos = data[3:0];
            CFG_BOOST:     boost_pos   = data[3:0];
            default: ;
        endcase
    endfunction

    // Queue the decision beat for a table position
    function void expect_decision(int p, bit boosted);
        out_t e;
        e.target_freq_khz = freq_at[p];
        e.table_position  = p[3:0];
        e.change_request  = (freq_at[p] != latched_freq);
        e.boost_applied   = boosted;
        expected_decisions.push_back(e);
        if (boosted) boosts++;
        if (e.change_request) changes++;
        if (p < pos_low) pos_low = p;
        if (p > pos_high) pos_high = p;
    endfunction

    // Advance the governor on one accepted sample beat
    function void note_sample(in_t b);
        int        cpu;
        int        bp;
        int        opt;
        bit [63:0] wall_step;
        bit [63:0] idle_step;
        bit [63:0] scaled;
        bit [31:0] dw;
        bit [31:0] di;

        samples++;
        cpu = int'(b.cpu_index);

        // First beat: clear the peak, latch the running frequency, try boost
        if (b.first_of_round) begin
            peak         = 0;
            skipping     = 0;
            latched_freq = b.current_freq_khz;
            if (b.boost_request) begin
                bp = (boost_pos > TOP_POS) ? int'(TOP_POS) : int'(boost_pos);
                if (b.current_freq_khz < freq_at[bp]) begin
                    pos = bp;
                    expect_decision(pos, 1'b1);
                    skipping = !b.last_of_round;
                    return;
                end
            end
        end

        // Drop the rest of a boosted round
        if (skipping) begin
            if (b.last_of_round) skipping = 0;
            return;
        end

        // Fold this CPU's load into the peak
        if (cpu < NUM_CPUS) begin
            wall_step = b.wall_time_us - last_wall[cpu];
            idle_step = b.idle_time_us - last_idle[cpu];
            dw = wall_step[31:0];
            di = idle_step[31:0];
            last_wall[cpu] = b.wall_time_us;
            last_idle[cpu] = b.idle_time_us;
            if (dw != 0 && dw >= di) begin
                scaled = 64'd100 * {32'd0, dw - di};
                scaled = scaled / {32'd0, dw};
                if (int'(scaled) > peak) peak = int'(scaled);
            end
        end

        if (!b.last_of_round) return;

        // Step the table position from the round's peak
        opt = int'(optimal_pos);
        if (peak > int'(up_base) + pos) begin
            pos++;
            if (pos < opt) pos = opt;
        end
        if (peak < int'(down_base) + pos) begin
            pos--;
            if (pos > opt) pos = opt;
        end
        if (pos > int'(TOP_POS)) pos = int'(TOP_POS);
        if (pos < 0) pos = 0;
        peak = 0;
        expect_decision(pos, 1'b0);
    endfunction

    task check_decision(out_t r);
        out_t e;
        if (expected_decisions.size() == 0) begin
            report($sformatf("decision beat with nothing expected: freq %0d pos %0d",
                             r.target_freq_khz, r.table_position));
            return;
        end
        e = expected_decisions.pop_front();
        decisions++;
        if (r.target_freq_khz !== e.target_freq_khz)
            report($sformatf("target_freq_khz got %0d want %0d",
                             r.target_freq_khz, e.target_freq_khz));
        if (r.table_position !== e.table_position)
            report($sformatf("table_position got %0d want %0d",
                             r.table_position, e.table_position));
        if (r.change_request !== e.change_request)
            report($sformatf("change_request got %0b want %0b",
                             r.change_request, e.change_request));
        if (r.boost_applied !== e.boost_applied)
            report($sformatf("boost_applied got %0b want %0b",
                             r.boost_applied, e.boost_applied));
    endtask
endclass

module load_based_frequency_step_governor_test;

    localparam int                   STUCK_LIMIT  = 5000;
    localparam int                   DRAIN_CYCLES = 40;
    localparam int                   HOLD_CYCLES  = 400;
    localparam int                   IN_W         = $bits(in_t);
    localparam logic [20:0]          FREQ_MAX     = 21'h1FFFFF;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'hA5;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    in_t                  s_data;
    logic                 m_valid;
    logic                 m_ready;
    out_t                 m_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    decision_scoreboard sb;
    bit                 steady;
    int                 sink_hold;
    int                 items_sent;
    int                 settings_used;
    int                 stuck_cycles;
    bit [63:0]          cpu_wall [NUM_CPUS];
    bit [63:0]          cpu_idle [NUM_CPUS];

    load_based_frequency_step_governor uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int sender_gap();
        if (steady || $urandom_range(0, 99) < 55) return 0;
        return pick_gap();
    endfunction

    function automatic in_t make_beat(int cpu, bit [63:0] wall, bit [63:0] idle,
                                      bit first, bit last, bit boost, bit [20:0] cur);
        in_t b;
        b.cpu_index        = cpu[1:0];
        b.wall_time_us     = wall;
        b.idle_time_us     = idle;
        b.first_of_round   = first;
        b.last_of_round    = last;
        b.boost_request    = boost;
        b.current_freq_khz = cur;
        return b;
    endfunction

    // Running frequency: table entries, near misses and arbitrary values
    function automatic bit [20:0] pick_freq();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return sb.freq_at[$urandom_range(0, 10)];
        if (r < 60) return sb.freq_at[$urandom_range(0, 10)] + 21'($urandom_range(0, 2)) - 21'd1;
        return 21'($urandom);
    endfunction

    // Advance one CPU's counters; mostly sane deltas at a load up to level percent
    function automatic void advance_counters(int cpu, int level);
        bit [63:0] dw;
        bit [63:0] di;
        int        r;
        int        busy;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            dw = 0;
            di = 64'($urandom_range(0, 1000));
        end else if (r < 8) begin
            dw = 64'($urandom_range(1, 1000));
            di = dw + 64'($urandom_range(1, 1000));
        end else if (r < 12) begin
            cpu_wall[cpu] = {$urandom, $urandom};
            cpu_idle[cpu] = {$urandom, $urandom};
            dw = 0;
            di = 0;
        end else if (r < 16) begin
            dw = 64'($urandom);
            di = dw * 64'($urandom_range(0, 100)) / 100;
        end else begin
            dw   = 64'($urandom_range(1, 200000));
            busy = $urandom_range(0, level);
            di   = dw - dw * 64'(busy) / 100;
        end
        cpu_wall[cpu] += dw;
        cpu_idle[cpu] += di;
    endfunction

    // Offer one sample beat and hold it until accepted; returns at the next falling edge
    task automatic send_beat(in_t b);
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic idle_sender(int n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
    endtask

    // Stop offering and wait for every expected decision
    task automatic drain();
        idle_sender(1);
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    task automatic write_register(bit [CFG_IDX_W-1:0] idx, bit [CFG_DAT_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Program all four registers once the block has gone quiet
    task automatic program_setting(bit [7:0] up, bit [7:0] down, bit [7:0] opt, bit [7:0] bst);
        drain();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        write_register(CFG_UP_BASE, up);
        write_register(CFG_DOWN_BASE, down);
        write_register(CFG_OPTIMAL, opt);
        write_register(CFG_BOOST, bst);
        settings_used++;
        @(negedge aclk);
    endtask

    // One round of samples, now and then without its first or last mark
    task automatic run_round();
        int        n;
        int        start;
        int        level;
        int        cpu;
        int        r;
        bit        drop_first;
        bit        drop_last;
        bit        boost;
        bit [20:0] cur;
        in_t       b;
        n          = $urandom_range(1, 4);
        start      = $urandom_range(0, 3);
        level      = $urandom_range(0, 100);
        r          = $urandom_range(0, 99);
        drop_first = (r < 6);
        drop_last  = (r >= 94);
        boost      = ($urandom_range(0, 99) < 15);
        cur        = pick_freq();
        for (int k = 0; k < n; k++) begin
            cpu = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 3) : (start + k) % NUM_CPUS;
            advance_counters(cpu, level);
            b = make_beat(cpu, cpu_wall[cpu], cpu_idle[cpu],
                          (k == 0) && !drop_first, (k == n - 1) && !drop_last,
                          (k == 0) ? boost : 1'($urandom), (k == 0) ? cur : 21'($urandom));
            send_beat(b);
            idle_sender(sender_gap());
        end
    endtask

    task automatic run_directed();
        bit [63:0] w;
        // Full-scale wall delta with no idle: top load in a one-beat round
        send_beat(make_beat(0, '1, '0, 1, 1, 0, '0));
        // Zero wall delta, idle ahead of wall, then a fully idle CPU
        send_beat(make_beat(1, '0, '0, 1, 0, 0, FREQ_MAX));
        send_beat(make_beat(2, 64'd100, 64'd200, 0, 0, 0, '0));
        send_beat(make_beat(3, 64'd1000, 64'd1000, 0, 1, 0, '0));
        // Boost below the boost frequency; the rest of the round is ignored
        send_beat(make_beat(0, 64'd5000, '0, 1, 0, 1, '0));
        send_beat(make_beat(1, 64'd7000, 64'd100, 0, 0, 1, FREQ_MAX));
        send_beat(make_beat(2, 64'd9000, 64'd10, 0, 1, 0, '0));
        // Boost requested at and above the boost frequency: normal decision
        send_beat(make_beat(0, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                            1, 0, 1, sb.freq_at[BOOST_RST]));
        send_beat(make_beat(1, '1, '1, 0, 1, 1, FREQ_MAX));
        // Boost on a one-beat round, one kHz under the boost frequency
        send_beat(make_beat(2, 64'h0000_0001_0000_0000, 64'h0000_0000_8000_0000,
                            1, 1, 1, sb.freq_at[BOOST_RST] - 21'd1));
        // Round with no first mark: middle beat then decision
        send_beat(make_beat(3, 64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF,
                            0, 0, 0, 21'h155555));
        send_beat(make_beat(0, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                            0, 1, 0, 21'h0AAAAA));
        // Heavy load climbs, then idle rounds bring the position back down
        w = 64'd1_000_000;
        for (int k = 0; k < 12; k++) begin
            w += 64'd10000;
            send_beat(make_beat(1, w, (k < 6) ? 64'd0 : w, 1, 1, 0, sb.freq_at[k % 11]));
            idle_sender(sender_gap());
        end
    endtask

    // Receiver: random stalls, plus a long hold when asked
    initial begin : result_sink
        int stall_left;
        m_ready    = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (sink_hold > 0) begin
                m_ready <= 1'b0;
                sink_hold--;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (!steady && $urandom_range(0, 99) < 30) begin
                m_ready <= 1'b0;
                stall_left = pick_gap() - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Sample handshakes and feed the scoreboard
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_decision(m_data);
            if (s_valid && s_ready) sb.note_sample(s_data);
            if (cfg_valid && cfg_ready) sb.set_register(cfg_index, cfg_data);
        end
    end

    // Give up when nothing moves on any channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles", STUCK_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin : stimulus
        int  phase_end;
        bit  drained;
        in_t b;
        sb            = new();
        steady        = 1'b0;
        sink_hold     = 0;
        items_sent    = 0;
        settings_used = 1;
        stuck_cycles  = 0;
        s_valid       = 1'b0;
        s_data        = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        foreach (cpu_wall[i]) begin
            cpu_wall[i] = {$urandom, $urandom};
            cpu_idle[i] = cpu_wall[i] - 64'($urandom_range(0, 100000));
        end
        aresetn = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        run_directed();

        for (int phase = 0; phase < 6; phase++) begin
            // Pick the register setting for this phase
            case (phase)
                1: program_setting(8'd0, 8'd0, 8'd0, 8'd0);
                2: program_setting(8'hFF, 8'h7F, 8'h0F, 8'hFF);
                3: program_setting(8'd100, 8'd100, 8'd10, 8'd10);
                4: begin
                    program_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                    write_register(REG_UNMAPPED, 8'($urandom));
                end
                5: begin
                    program_setting(8'd55, 8'd20, 8'd3, 8'd7);
                    steady = 1'b1;
                end
                default: ;
            endcase
            // Hold the receiver off while the sender keeps offering
            if (phase == 2) sink_hold = HOLD_CYCLES;
            phase_end = items_sent + 90;
            drained   = 1'b0;
            while (items_sent < phase_end) begin
                if (phase == 3 && !drained && items_sent > phase_end - 45) begin
                    drain();
                    drained = 1'b1;
                end
                if ($urandom_range(0, 99) < 8) begin
                    b = in_t'(IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));
                    send_beat(b);
                    idle_sender(sender_gap());
                end else begin
                    run_round();
                end
            end
        end

        // Let the last decisions come out
        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d decisions never arrived", sb.pending()));

        $display("Run: %0d sample beats, %0d decisions checked (%0d boosted, %0d changes)",
                 sb.samples, sb.decisions, sb.boosts, sb.changes);
        $display("Run: %0d register writes over %0d settings, positions %0d to %0d",
                 sb.reg_writes, settings_used, sb.pos_low, sb.pos_high);
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
src/lbfsg_pkg.sv
src/load_based_frequency_step_governor.sv
src/lbfsg_checker.sv
test/load_based_frequency_step_governor_test.sv
